>>> hw/rtl/vds24_pkg.sv
// Shared types and constants for the 24-sector vector direction block.
// Holds the tangent threshold table, built at elaboration. No dependencies.
package vds24_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS      = 40;
  localparam int TRIG_Q         = 60;
  localparam int MAX_DEG        = 89;
  localparam int DEG_BITS       = 7;
  localparam int TAB_DEPTH      = 1 << DEG_BITS;
  localparam int TAN_BITS       = 46;
  localparam int TAN_LO_BITS    = 23;
  localparam int STEP_DEG       = 15;
  localparam int NUM_SECTORS    = 24;
  localparam int SECTOR_BITS    = 5;
  localparam int ANGLE_BITS     = 9;
  localparam int HALF_TURN      = 180;
  localparam int FULL_TURN      = 360;
  localparam int RECIP_SHIFT    = 16;
  localparam int RECIP_15       = (1 << RECIP_SHIFT) / STEP_DEG + 1;
  localparam int RECIP_BITS     = 13;

  localparam logic [63:0] P_NUM     = 64'd31415926536;
  localparam logic [63:0] P_DEN_180 = 64'd1800000000000;

  typedef struct packed {
    logic coinc;   // both points equal
    logic neg;     // angle sign before the half-turn offset
    logic dy_neg;  // vector points into the lower half-plane
  } flags_t;

  typedef logic [TAB_DEPTH-1:0][TAN_BITS-1:0] tan_tab_t;

  // Restoring long division, low 64 quotient bits.
  function automatic logic [63:0] div_q(logic [127:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      q   = {q[62:0], 1'b0};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Restoring long division of a 64-bit dividend.
  function automatic logic [63:0] div_n(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      q   = {q[62:0], 1'b0};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q60 product, truncated.
  function automatic logic [63:0] mul_q(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[TRIG_Q +: 64];
  endfunction

  // tan(k degrees) with 40 fractional bits, from Q60 sine and cosine series.
  function automatic logic [63:0] tan_entry(int k);
    logic [127:0]       num;
    logic [63:0]        kp, theta, x2, ts, tc, s, c;
    logic signed [63:0] ss, sc;
    kp    = 64'(k) * P_NUM;
    num   = {64'd0, kp} << TRIG_Q;
    theta = div_q(num, P_DEN_180);
    x2    = mul_q(theta, theta);
    ts    = theta;
    tc    = 64'd1 << TRIG_Q;
    ss    = $signed(ts);
    sc    = $signed(tc);
    for (int n = 1; n <= 20; n++) begin
      ts = div_n(mul_q(ts, x2), 64'((2 * n) * (2 * n + 1)));
      tc = div_n(mul_q(tc, x2), 64'((2 * n - 1) * (2 * n)));
      if ((n & 1) != 0) begin
        ss = ss - $signed(ts);
        sc = sc - $signed(tc);
      end else begin
        ss = ss + $signed(ts);
        sc = sc + $signed(tc);
      end
    end
    s   = (ss > 0) ? $unsigned(ss) : 64'd0;
    c   = (sc > 0) ? $unsigned(sc) : 64'd1;
    num = ({64'd0, s} << FRAC_BITS) + {65'd0, c[63:1]};
    return div_q(num, c);
  endfunction

  function automatic tan_tab_t build_tan();
    tan_tab_t t;
    t = '0;
    for (int k = 1; k <= MAX_DEG; k++) begin
      t[k] = TAN_BITS'(tan_entry(k));
    end
    return t;
  endfunction

  localparam tan_tab_t TAN_TAB = build_tan();

endpackage

>>> hw/rtl/vector_direction_sector24.sv
// Vector direction sector, 24 sectors of fifteen degrees each.
//
// Give a request on the input channel: two points (from, to) as signed
// COORD_BITS-wide coordinates. A request is taken at a rising edge where
// in_valid_i is high and in_stall_o is low. The result channel returns
// sector_o in 1..24 when out_valid_o is high and out_stall_i is low.
// Coincident points give sector 1.
//
// A request passes sixteen register ranks: one input rank, seven search
// cells of two ranks each, one output rank. While out_stall_i is low the
// block takes one request per cycle; each search cell holds one multiply
// rank and one compare rank, and the compare of the widest product sets
// the clock.
// Every rank carries its own valid bit; a rank loads when it is empty or
// when the rank after it moves. With out_stall_i high, the output register
// holds its result and the ranks behind it keep filling until the row is
// full, then in_stall_o rises. Reset clears every valid bit; the block
// takes requests in the first cycle after reset is released.
module vector_direction_sector24 #(
  parameter int COORD_BITS = vds24_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COORD_BITS-1:0]      from_x_i,
  input  logic signed [COORD_BITS-1:0]      from_y_i,
  input  logic signed [COORD_BITS-1:0]      to_x_i,
  input  logic signed [COORD_BITS-1:0]      to_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [vds24_pkg::SECTOR_BITS-1:0] sector_o
);
  import vds24_pkg::*;

  // Links of the cell row; index 0 comes from the input rank.
  logic                  ch_valid [DEG_BITS+1];
  logic                  ch_ready [DEG_BITS+1];
  logic [COORD_BITS-1:0] ch_a     [DEG_BITS+1];
  logic [COORD_BITS-1:0] ch_b     [DEG_BITS+1];
  logic [DEG_BITS-1:0]   ch_m     [DEG_BITS+1];
  flags_t                ch_flags [DEG_BITS+1];

  vds24_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .from_x_i   (from_x_i),
    .from_y_i   (from_y_i),
    .to_x_i     (to_x_i),
    .to_y_i     (to_y_i),
    .dn_valid_o (ch_valid[0]),
    .dn_ready_i (ch_ready[0]),
    .dn_a_o     (ch_a[0]),
    .dn_b_o     (ch_b[0]),
    .dn_flags_o (ch_flags[0])
  );

  // Start the search from zero degrees.
  assign ch_m[0] = '0;

  // Decide the degree magnitude most significant bit first, one bit a cell.
  for (genvar j = 0; j < DEG_BITS; j++) begin : g_cell
    vds24_cell #(
      .COORD_BITS(COORD_BITS),
      .BIT_IDX   (DEG_BITS - 1 - j)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (ch_valid[j]),
      .up_ready_o (ch_ready[j]),
      .up_a_i     (ch_a[j]),
      .up_b_i     (ch_b[j]),
      .up_m_i     (ch_m[j]),
      .up_flags_i (ch_flags[j]),
      .dn_valid_o (ch_valid[j+1]),
      .dn_ready_i (ch_ready[j+1]),
      .dn_a_o     (ch_a[j+1]),
      .dn_b_o     (ch_b[j+1]),
      .dn_m_o     (ch_m[j+1]),
      .dn_flags_o (ch_flags[j+1])
    );
  end

  vds24_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .up_valid_i  (ch_valid[DEG_BITS]),
    .up_ready_o  (ch_ready[DEG_BITS]),
    .up_m_i      (ch_m[DEG_BITS]),
    .up_flags_i  (ch_flags[DEG_BITS]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sector_o    (sector_o)
  );

endmodule

>>> hw/rtl/vds24_front.sv
// Input rank: coordinate differences, magnitudes and direction flags.
// Depends on vds24_pkg.
module vds24_front #(
  parameter int COORD_BITS = vds24_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] from_x_i,
  input  logic signed [COORD_BITS-1:0] from_y_i,
  input  logic signed [COORD_BITS-1:0] to_x_i,
  input  logic signed [COORD_BITS-1:0] to_y_i,
  output logic                         dn_valid_o,
  input  logic                         dn_ready_i,
  output logic [COORD_BITS-1:0]        dn_a_o,
  output logic [COORD_BITS-1:0]        dn_b_o,
  output vds24_pkg::flags_t            dn_flags_o
);
  import vds24_pkg::*;

  logic                  ready;
  logic                  valid_q, valid_d;
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS-1:0] a_q, a_d, b_q, b_d;
  flags_t                flags_q, flags_d;

  assign ready      = !valid_q || dn_ready_i;
  assign in_stall_o = !ready;

  always_comb begin
    dx = {from_x_i[COORD_BITS-1], from_x_i} - {to_x_i[COORD_BITS-1], to_x_i};
    dy = {to_y_i[COORD_BITS-1], to_y_i} - {from_y_i[COORD_BITS-1], from_y_i};
    // A difference of two coordinates never reaches 2^COORD_BITS in magnitude.
    a_d = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    b_d = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    flags_d.coinc  = (dx == '0) && (dy == '0);
    flags_d.neg    = dx[COORD_BITS] != dy[COORD_BITS];
    flags_d.dy_neg = dy[COORD_BITS];
    valid_d = ready ? in_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready) begin
      a_q     <= a_d;
      b_q     <= b_d;
      flags_q <= flags_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_a_o     = a_q;
  assign dn_b_o     = b_q;
  assign dn_flags_o = flags_q;

endmodule

>>> hw/rtl/vds24_cell.sv
// One search cell: decides a single bit of the whole-degree magnitude by
// comparing |dx|*2^40 against |dy|*tan. Depends on vds24_pkg.
module vds24_cell #(
  parameter int COORD_BITS = vds24_pkg::COORD_BITS_DEF,
  parameter int BIT_IDX    = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          up_valid_i,
  output logic                          up_ready_o,
  input  logic [COORD_BITS-1:0]         up_a_i,
  input  logic [COORD_BITS-1:0]         up_b_i,
  input  logic [vds24_pkg::DEG_BITS-1:0] up_m_i,
  input  vds24_pkg::flags_t             up_flags_i,
  output logic                          dn_valid_o,
  input  logic                          dn_ready_i,
  output logic [COORD_BITS-1:0]         dn_a_o,
  output logic [COORD_BITS-1:0]         dn_b_o,
  output logic [vds24_pkg::DEG_BITS-1:0] dn_m_o,
  output vds24_pkg::flags_t             dn_flags_o
);
  import vds24_pkg::*;

  localparam int HI_BITS  = TAN_BITS - TAN_LO_BITS;
  localparam int PHI_W    = COORD_BITS + HI_BITS;
  localparam int PLO_W    = COORD_BITS + TAN_LO_BITS;
  localparam int PROD_W   = COORD_BITS + TAN_BITS;
  localparam logic [DEG_BITS-1:0] BIT_MASK = DEG_BITS'(1) << BIT_IDX;
  localparam logic [DEG_BITS-1:0] LOW_MASK = BIT_MASK - DEG_BITS'(1);

  // Multiply rank
  logic                  rdy_a;
  logic                  va_q, va_d;
  logic [DEG_BITS-1:0]   cand;
  logic [TAN_BITS-1:0]   tan_val;
  logic [DEG_BITS-1:0]   m_a_q, cand_a_q;
  logic                  ok_a_q;
  logic [COORD_BITS-1:0] a_a_q, b_a_q;
  flags_t                flags_a_q;
  logic [PHI_W-1:0]      phi_q, phi_d;
  logic [PLO_W-1:0]      plo_q, plo_d;

  // Compare rank
  logic                  rdy_b;
  logic                  vb_q, vb_d;
  logic [PROD_W-1:0]     prod, lhs;
  logic                  pass;
  logic [DEG_BITS-1:0]   m_b_q, m_b_d;
  logic [COORD_BITS-1:0] a_b_q, b_b_q;
  flags_t                flags_b_q;

  assign rdy_b      = !vb_q || dn_ready_i;
  assign rdy_a      = !va_q || rdy_b;
  assign up_ready_o = rdy_a;

  always_comb begin
    cand    = up_m_i | BIT_MASK;
    tan_val = TAN_TAB[cand];
    phi_d   = PHI_W'(up_b_i) * PHI_W'(tan_val[TAN_BITS-1:TAN_LO_BITS]);
    plo_d   = PLO_W'(up_b_i) * PLO_W'(tan_val[TAN_LO_BITS-1:0]);
    va_d    = rdy_a ? up_valid_i : va_q;
  end

  always_comb begin
    prod  = {phi_q, {TAN_LO_BITS{1'b0}}} + PROD_W'(plo_q);
    lhs   = PROD_W'({a_a_q, {FRAC_BITS{1'b0}}});
    // Candidates past the last degree never pass.
    pass  = ok_a_q && (lhs >= prod);
    m_b_d = pass ? cand_a_q : m_a_q;
    vb_d  = rdy_b ? va_q : vb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= va_d;
      vb_q <= vb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      m_a_q     <= up_m_i;
      cand_a_q  <= cand;
      ok_a_q    <= cand <= DEG_BITS'(MAX_DEG);
      a_a_q     <= up_a_i;
      b_a_q     <= up_b_i;
      flags_a_q <= up_flags_i;
      phi_q     <= phi_d;
      plo_q     <= plo_d;
    end
    if (rdy_b) begin
      m_b_q     <= m_b_d;
      a_b_q     <= a_a_q;
      b_b_q     <= b_a_q;
      flags_b_q <= flags_a_q;
    end
  end

  assign dn_valid_o = vb_q;
  assign dn_a_o     = a_b_q;
  assign dn_b_o     = b_b_q;
  assign dn_m_o     = m_b_q;
  assign dn_flags_o = flags_b_q;

  // Bits below this cell's bit are decided further down the row.
  a_low_bits_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q |-> ((m_b_q & LOW_MASK) == '0))
    else $error("search bits below the current cell are already set");

  a_m_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q |-> (m_b_q <= DEG_BITS'(MAX_DEG)))
    else $error("degree magnitude beyond the last table entry");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vb_q && !dn_ready_i) |=> (vb_q && $stable(m_b_q) && $stable(flags_b_q)))
    else $error("cell dropped or changed a held request");

endmodule

>>> hw/rtl/vds24_back.sv
// Output rank: applies sign and half-turn offset, maps degrees to a sector.
// Depends on vds24_pkg.
module vds24_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              up_valid_i,
  output logic                              up_ready_o,
  input  logic [vds24_pkg::DEG_BITS-1:0]    up_m_i,
  input  vds24_pkg::flags_t                 up_flags_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [vds24_pkg::SECTOR_BITS-1:0] sector_o
);
  import vds24_pkg::*;

  localparam int PROD_W = ANGLE_BITS + RECIP_BITS;

  logic                   ready;
  logic                   valid_q, valid_d;
  logic [ANGLE_BITS-1:0]  m9, angle;
  logic [PROD_W-1:0]      prod;
  logic [SECTOR_BITS-1:0] sec_raw, sector_q, sector_d;

  assign ready      = !valid_q || !out_stall_i;
  assign up_ready_o = ready;

  always_comb begin
    m9 = ANGLE_BITS'(up_m_i);
    if (!up_flags_i.dy_neg && !up_flags_i.neg) begin
      angle = m9;
    end else if (!up_flags_i.dy_neg) begin
      angle = (m9 == '0) ? '0 : ANGLE_BITS'(FULL_TURN) - m9;
    end else if (!up_flags_i.neg) begin
      angle = ANGLE_BITS'(HALF_TURN) + m9;
    end else begin
      angle = ANGLE_BITS'(HALF_TURN) - m9;
    end
    // Divide by fifteen through a reciprocal; exact for angles below a full turn.
    prod    = PROD_W'(angle) * PROD_W'(RECIP_15);
    sec_raw = prod[RECIP_SHIFT +: SECTOR_BITS] + SECTOR_BITS'(1);
    if (up_flags_i.coinc || sec_raw > SECTOR_BITS'(NUM_SECTORS)) begin
      sector_d = SECTOR_BITS'(1);
    end else begin
      sector_d = sec_raw;
    end
    valid_d = ready ? up_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready) begin
      sector_q <= sector_d;
    end
  end

  assign out_valid_o = valid_q;
  assign sector_o    = sector_q;

endmodule
